### rtl/kest_pkg.sv
`timescale 1ns / 1ps

package kest_pkg;

  // default sizes
  localparam int MAX_KEYS_DEF   = 256;
  localparam int FIFO_DEPTH_DEF = 64;

  // key states
  localparam logic [1:0] ST_UP       = 2'd0;
  localparam logic [1:0] ST_DOWN     = 2'd1;
  localparam logic [1:0] ST_PRESSED  = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  // posted event kinds (anything else acts as repeat)
  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_REPEAT   = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;

  // item modes
  localparam logic [1:0] MODE_POST   = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_QSTATE = 2'd2;
  localparam logic [1:0] MODE_QLAST  = 2'd3;

  // config register indexes and reset values
  localparam logic [0:0] CFG_KEYS_IN_USE = 1'b0;
  localparam logic [0:0] CFG_ANY_KEY     = 1'b1;
  localparam logic [8:0] KEYS_IN_USE_RST = 9'd256;
  localparam logic [7:0] ANY_KEY_RST     = 8'd255;
  localparam logic [7:0] LAST_KEY_RST    = 8'd255;

  // one queued event
  typedef struct packed {
    logic [7:0] key;
    logic [1:0] etype;
  } kest_evt_t;

  // event queue control
  typedef struct packed {
    logic      push;
    logic      clear;
    kest_evt_t evt;
  } kest_fifo_ctl_t;

  // result item, packed as on out_tdata
  typedef struct packed {
    logic [6:0] pad;
    logic [6:0] processed_count;
    logic [7:0] last_key;
    logic       matches_res;
    logic       accepted;
  } kest_res_t;

  // down also matches pressed
  function automatic logic st_match(input logic [1:0] have, input logic [1:0] want);
    st_match = (have == want) || ((want == ST_DOWN) && (have == ST_PRESSED));
  endfunction

endpackage

### rtl/key_edge_state_tracker.sv
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents (lowest bit up)
// in_      in   16     mode[1:0], key[9:2], event_type[11:10], query_state[13:12], zero pad
// out_     out  24     accepted[0], matches_res[1], last_key[9:2], processed_count[16:10], pad
// cfg_     in   1/9    index 0 keys_in_use, index 1 any_key_code; write when cfg_we
//
// Post and last-key query: answered when taken. Single-key query: one key RAM read, then a compare.
// Any-key query: walks keys 0 to n-1, n = min(keys_in_use, MAX_KEYS), a read and a compare per key.
// Flush: take the item, age the key RAM (a read and a write per key), then per queued event a
// queue read, and for an in-range key a key RAM read and a write back; then finish.
// Reset: a clearing pass sets every key RAM entry to up; no item is taken during it.
// Under a stalled sink the next item is still taken; its result parks until out_ frees.
module key_edge_state_tracker #(
  parameter int MAX_KEYS   = kest_pkg::MAX_KEYS_DEF,
  parameter int FIFO_DEPTH = kest_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // mode, key, event_type, query_state
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // accepted, matches_res, last_key, processed_count
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);
  import kest_pkg::*;

  localparam int KEY_AW  = $clog2(MAX_KEYS);
  localparam int NW      = ($clog2(MAX_KEYS + 1) > 9) ? $clog2(MAX_KEYS + 1) : 9;
  localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCW     = $clog2(FIFO_DEPTH + 1);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;   // reset clearing pass
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_QCK  = 4'd2;   // single-key compare
  localparam logic [3:0] S_AWRD = 4'd3;   // any-key walk read
  localparam logic [3:0] S_AWCK = 4'd4;   // any-key walk compare
  localparam logic [3:0] S_FLRD = 4'd5;   // flush aging read
  localparam logic [3:0] S_FLWR = 4'd6;   // flush aging write
  localparam logic [3:0] S_DRF  = 4'd7;   // drain: queue read
  localparam logic [3:0] S_DRT  = 4'd8;   // drain: key RAM read
  localparam logic [3:0] S_DRW  = 4'd9;   // drain: write back
  localparam logic [3:0] S_RESP = 4'd10;  // result waits for output register

  // config
  logic [8:0] keys_in_use_r;
  logic [7:0] any_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_in_use_r <= KEYS_IN_USE_RST;
      any_key_r     <= ANY_KEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEYS_IN_USE: keys_in_use_r <= cfg_wdata;
        CFG_ANY_KEY:     any_key_r     <= cfg_wdata[7:0];
      endcase
    end
  end

  // valid key count, clamped to the table size
  logic [NW-1:0] keys_ext;
  logic [NW-1:0] n_w;
  assign keys_ext = NW'(keys_in_use_r);
  assign n_w      = (keys_ext > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : keys_ext;

  // input fields
  logic [1:0] in_mode;
  logic [7:0] in_key;
  logic [1:0] in_etype;
  logic [1:0] in_qstate;
  assign in_mode   = in_tdata[1:0];
  assign in_key    = in_tdata[9:2];
  assign in_etype  = in_tdata[11:10];
  assign in_qstate = in_tdata[13:12];

  // sequencer registers
  logic [3:0]        st_r,   st_nxt;
  logic [KEY_AW-1:0] idx_r,  idx_nxt;
  logic [FCW-1:0]    ev_r,   ev_nxt;
  logic [6:0]        cnt_r,  cnt_nxt;
  logic [7:0]        ek_r,   ek_nxt;
  logic [1:0]        et_r,   et_nxt;
  logic [1:0]        qst_r,  qst_nxt;
  logic [7:0]        last_r   [4];
  logic [7:0]        last_nxt [4];
  logic              out_valid_r, out_valid_nxt;
  kest_res_t         out_data_r,  out_data_nxt;
  kest_res_t         res_r,       res_nxt;

  // memory ports
  logic              tbl_we;
  logic [KEY_AW-1:0] tbl_waddr;
  logic [1:0]        tbl_wdata;
  logic [KEY_AW-1:0] tbl_raddr;
  logic [1:0]        tbl_rdata;
  kest_fifo_ctl_t    fifo_ctl;
  logic [FIFO_AW-1:0] fifo_ridx;
  kest_evt_t         fifo_rdata;
  logic [FCW-1:0]    fifo_count;
  logic              fifo_full;

  logic              fin;
  kest_res_t         fin_res;
  logic              slot_free;
  logic [1:0]        s_new;
  logic              in_acc;

  assign fifo_full = (fifo_count == FCW'(FIFO_DEPTH));
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // drain update: pressed/released set the state, repeat keeps it
  always_comb begin
    if (et_r == EV_PRESSED) begin
      s_new = ST_PRESSED;
    end else if (et_r == EV_RELEASED) begin
      s_new = ST_RELEASED;
    end else begin
      s_new = tbl_rdata;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    ev_nxt    = ev_r;
    cnt_nxt   = cnt_r;
    ek_nxt    = ek_r;
    et_nxt    = et_r;
    qst_nxt   = qst_r;
    for (int i = 0; i < 4; i++) begin
      last_nxt[i] = last_r[i];
    end
    tbl_we    = 1'b0;
    tbl_waddr = idx_r;
    tbl_wdata = ST_UP;
    tbl_raddr = idx_r;
    fifo_ctl.push  = 1'b0;
    fifo_ctl.clear = 1'b0;
    fifo_ctl.evt   = '{key: in_key, etype: in_etype};
    fifo_ridx = ev_r[FIFO_AW-1:0];
    fin       = 1'b0;
    fin_res   = '0;

    unique case (st_r)
      S_CLR: begin
        tbl_we = 1'b1;
        if (idx_r == KEY_AW'(MAX_KEYS - 1)) begin
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + KEY_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_POST: begin
              fin              = 1'b1;
              fifo_ctl.push    = !fifo_full;
              fin_res.accepted = !fifo_full;
            end
            MODE_FLUSH: begin
              idx_nxt = '0;
              ev_nxt  = '0;
              cnt_nxt = '0;
              st_nxt  = (n_w == '0) ? S_DRF : S_FLRD;
            end
            MODE_QSTATE: begin
              qst_nxt = in_qstate;
              if (NW'(in_key) >= n_w) begin
                fin = 1'b1;
              end else if (in_key == any_key_r) begin
                idx_nxt = '0;
                st_nxt  = S_AWRD;
              end else begin
                tbl_raddr = KEY_AW'(in_key);
                st_nxt    = S_QCK;
              end
            end
            MODE_QLAST: begin
              fin              = 1'b1;
              fin_res.last_key = last_r[in_qstate];
            end
          endcase
        end
      end
      S_QCK: begin
        fin                 = 1'b1;
        fin_res.matches_res = st_match(tbl_rdata, qst_r);
      end
      S_AWRD: begin
        st_nxt = S_AWCK;
      end
      S_AWCK: begin
        if (st_match(tbl_rdata, qst_r)) begin
          fin                 = 1'b1;
          fin_res.matches_res = 1'b1;
        end else if (NW'(idx_r) + NW'(1) == n_w) begin
          fin = 1'b1;
        end else begin
          idx_nxt = idx_r + KEY_AW'(1);
          st_nxt  = S_AWRD;
        end
      end
      S_FLRD: begin
        st_nxt = S_FLWR;
      end
      S_FLWR: begin
        tbl_we    = 1'b1;
        tbl_wdata = ((tbl_rdata == ST_PRESSED) || (tbl_rdata == ST_DOWN)) ? ST_DOWN : ST_UP;
        if (NW'(idx_r) + NW'(1) == n_w) begin
          st_nxt = S_DRF;
        end else begin
          idx_nxt = idx_r + KEY_AW'(1);
          st_nxt  = S_FLRD;
        end
      end
      S_DRF: begin
        if (ev_r == fifo_count) begin
          fin                     = 1'b1;
          fifo_ctl.clear          = 1'b1;
          fin_res.processed_count = cnt_r;
        end else begin
          st_nxt = S_DRT;
        end
      end
      S_DRT: begin
        if (NW'(fifo_rdata.key) >= n_w) begin
          ev_nxt = ev_r + FCW'(1);
          st_nxt = S_DRF;
        end else begin
          tbl_raddr = KEY_AW'(fifo_rdata.key);
          ek_nxt    = fifo_rdata.key;
          et_nxt    = fifo_rdata.etype;
          st_nxt    = S_DRW;
        end
      end
      S_DRW: begin
        tbl_we    = 1'b1;
        tbl_waddr = KEY_AW'(ek_r);
        tbl_wdata = s_new;
        if (s_new == ST_PRESSED) begin
          last_nxt[ST_DOWN] = ek_r;
        end
        last_nxt[s_new] = ek_r;
        cnt_nxt = cnt_r + 7'd1;
        ev_nxt  = ev_r + FCW'(1);
        st_nxt  = S_DRF;
      end
      S_RESP: begin
        st_nxt = S_RESP;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // output register: load a finished result, or park it until the sink takes the last
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    if (fin) begin
      if (slot_free) begin
        out_data_nxt  = fin_res;
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end else begin
        res_nxt = fin_res;
        st_nxt  = S_RESP;
      end
    end
    if ((st_r == S_RESP) && slot_free) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
      st_nxt        = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      idx_r       <= '0;
      ev_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        last_r[i] <= LAST_KEY_RST;
      end
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      ev_r        <= ev_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) begin
        last_r[i] <= last_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    ek_r       <= ek_nxt;
    et_r       <= et_nxt;
    qst_r      <= qst_nxt;
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  kest_key_ram #(
    .DEPTH (MAX_KEYS),
    .AW    (KEY_AW)
  ) u_key_ram (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr   (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  kest_evt_fifo #(
    .DEPTH (FIFO_DEPTH),
    .AW    (FIFO_AW),
    .CW    (FCW)
  ) u_evt_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .ridx    (fifo_ridx),
    .rd_data (fifo_rdata),
    .count   (fifo_count)
  );

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= FCW'(FIFO_DEPTH))
    else $error("event queue count above depth");

  // an accepted post into a non-full queue grows it by one
  a_post_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_POST) && !fifo_full)
      |=> (fifo_count == $past(fifo_count) + FCW'(1)))
    else $error("post not queued");

  // a parked result only exists while the output register is occupied
  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RESP) |-> out_valid_r)
    else $error("result parked with free output register");

  // drain write-back only for in-range keys
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DRW) |-> (NW'(ek_r) < n_w))
    else $error("out-of-range key applied");

endmodule

### rtl/kest_key_ram.sv
`timescale 1ns / 1ps

module kest_key_ram #(
  parameter int DEPTH = kest_pkg::MAX_KEYS_DEF,
  parameter int AW    = $clog2(kest_pkg::MAX_KEYS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/kest_evt_fifo.sv
`timescale 1ns / 1ps

module kest_evt_fifo #(
  parameter int DEPTH = kest_pkg::FIFO_DEPTH_DEF,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kest_pkg::kest_fifo_ctl_t ctl,
  input  logic [AW-1:0]           ridx,
  output kest_pkg::kest_evt_t     rd_data,
  output logic [CW-1:0]           count
);
  import kest_pkg::*;

  kest_evt_t     mem [DEPTH];
  kest_evt_t     rd_data_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // push is gated by the caller when full
  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count_r[AW-1:0]] <= ctl.evt;
    end
    rd_data_r <= mem[ridx];
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

### test/key_edge_state_tracker_check.sv
`timescale 1ns / 1ps

module key_edge_state_tracker_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // mode, key, event_type, query_state
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // accepted, matches_res, last_key, processed_count
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_results
);

  import kest_pkg::*;

  logic [1:0] key_tbl [MAX_KEYS_DEF];
  logic [7:0] last_key_of [4];
  kest_evt_t  posted_events[$];
  logic [8:0] keys_in_use_r;
  logic [7:0] any_key_r;
  kest_res_t  owed_results[$];
  kest_res_t  got_res;
  kest_res_t  want_res;

  // down also answers for pressed
  function automatic logic reads_as(input logic [1:0] have, input logic [1:0] asked);
    reads_as = (have == asked) || (asked == ST_DOWN && have == ST_PRESSED);
  endfunction

  function automatic kest_res_t key_result(input logic [15:0] item);
    logic [1:0] mode;
    logic [7:0] key;
    logic [1:0] etype;
    logic [1:0] qst;
    logic [1:0] s;
    logic [7:0] ek;
    int         n;
    int         applied;
    int         i;
    kest_res_t  res;
    mode  = item[1:0];
    key   = item[9:2];
    etype = item[11:10];
    qst   = item[13:12];
    n     = (keys_in_use_r > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(keys_in_use_r);
    res   = '0;
    case (mode)
      MODE_POST: begin
        if (posted_events.size() < FIFO_DEPTH_DEF) begin
          posted_events.push_back({key, etype});
          res.accepted = 1'b1;
        end
      end
      MODE_FLUSH: begin
        applied = 0;
        for (i = 0; i < n; i++)
          key_tbl[i] = (key_tbl[i] == ST_PRESSED || key_tbl[i] == ST_DOWN) ? ST_DOWN : ST_UP;
        for (i = 0; i < posted_events.size(); i++) begin
          ek = posted_events[i].key;
          if (ek < n) begin
            if (posted_events[i].etype == EV_PRESSED)
              key_tbl[ek] = ST_PRESSED;
            else if (posted_events[i].etype == EV_RELEASED)
              key_tbl[ek] = ST_RELEASED;
            s = key_tbl[ek];
            if (s == ST_PRESSED)
              last_key_of[ST_DOWN] = ek;
            last_key_of[s] = ek;
            applied++;
          end
        end
        posted_events.delete();
        res.processed_count = 7'(applied);
      end
      MODE_QSTATE: begin
        if (key < n) begin
          if (key == any_key_r) begin
            for (i = 0; i < n; i++)
              if (reads_as(key_tbl[i], qst))
                res.matches_res = 1'b1;
          end else begin
            res.matches_res = reads_as(key_tbl[key], qst);
          end
        end
      end
      default: begin
        res.last_key = last_key_of[qst];
      end
    endcase
    key_result = res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KEYS_DEF; i++)
        key_tbl[i] = ST_UP;
      for (int i = 0; i < 4; i++)
        last_key_of[i] = LAST_KEY_RST;
      keys_in_use_r = KEYS_IN_USE_RST;
      any_key_r     = ANY_KEY_RST;
      posted_events.delete();
      owed_results.delete();
      pending_results <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_KEYS_IN_USE)
          keys_in_use_r = cfg_wdata;
        else
          any_key_r = cfg_wdata[7:0];
      end
      // results first: an item taken at this edge cannot have its result out yet
      if (out_tvalid && out_tready) begin
        got_res = out_tdata;
        if (owed_results.size() == 0) begin
          $error("out_tdata: expected no item, got %h", out_tdata);
          fail_count++;
        end else begin
          want_res = owed_results.pop_front();
          check_field("accepted", want_res.accepted, got_res.accepted);
          check_field("matches_res", want_res.matches_res, got_res.matches_res);
          check_field("last_key", want_res.last_key, got_res.last_key);
          check_field("processed_count", want_res.processed_count, got_res.processed_count);
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(key_result(in_tdata));
      pending_results <= owed_results.size();
    end
  end

endmodule

### test/key_edge_state_tracker_test.sv
`timescale 1ns / 1ps

module key_edge_state_tracker_test;

  import kest_pkg::*;

  // worst item is a full flush at 256 keys with a full queue; real runs are far shorter
  localparam int CYCLE_LIMIT = 2_000_000;
  // tail wait after the last result: longer than the slowest item
  localparam int TAIL_CYCLES = 800;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // mode, key, event_type, query_state, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // accepted, matches_res, last_key, processed_count, pad
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [8:0]  cfg_wdata;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int items_sent;
  int send_idle_pct = 0;    // chance per cycle that the sender holds off
  int stall_pct = 0;        // chance per cycle that the sink stalls
  int cur_keys = KEYS_IN_USE_RST;
  int cur_any = ANY_KEY_RST;

  always #10 clk = ~clk;

  key_edge_state_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  key_edge_state_tracker_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // sink backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] make_item(input logic [1:0] mode, input logic [7:0] key,
                                            input logic [1:0] etype, input logic [1:0] qst);
    make_item = {2'b00, qst, etype, key, mode};
  endfunction

  // mostly keys inside the valid range, some anywhere
  function automatic logic [7:0] pick_key();
    int n;
    n = (cur_keys > MAX_KEYS_DEF) ? MAX_KEYS_DEF : cur_keys;
    if (n > 0 && $urandom_range(0, 9) < 8)
      pick_key = 8'($urandom_range(0, n - 1));
    else
      pick_key = 8'($urandom_range(0, 255));
  endfunction

  // Called at a rising edge, returns at the edge the item is taken.
  // tvalid stays up between back-to-back items.
  task automatic send_item(input logic [15:0] item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every owed result is out; the pending count is registered and lags
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0)
      @(posedge clk);
  endtask

  // both registers, back to back; only called with the block idle
  task automatic program_cfg(input int keys, input int any_key);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_KEYS_IN_USE;
    cfg_wdata <= 9'(keys);
    @(posedge clk);
    cfg_addr  <= CFG_ANY_KEY;
    cfg_wdata <= 9'(any_key);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_keys = keys;
    cur_any  = any_key;
  endtask

  // One frame: a burst of posts, a flush, then a few queries.
  // Some frames skip the flush so events pile up (and overflow); a few are pure noise.
  task automatic run_frame();
    int          r;
    int          posts;
    int          queries;
    int          i;
    logic [15:0] noise;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      noise = {2'b00, 14'($urandom())};
      send_item(noise);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85)
        posts = $urandom_range(0, 8);
      else if (r < 95)
        posts = $urandom_range(9, 30);
      else
        posts = $urandom_range(60, 70);   // runs past the queue depth
      for (i = 0; i < posts; i++)
        send_item(make_item(MODE_POST, pick_key(), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3))));
      if ($urandom_range(0, 9) != 0)
        send_item(make_item(MODE_FLUSH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3))));
      queries = $urandom_range(1, 4);
      for (i = 0; i < queries; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_item(make_item(MODE_QLAST, 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
        else if ($urandom_range(0, 9) < 3)
          send_item(make_item(MODE_QSTATE, 8'(cur_any), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3))));
        else
          send_item(make_item(MODE_QSTATE, pick_key(), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3))));
      end
    end
    // occasional full pause mid-phase
    if ($urandom_range(0, 29) == 0)
      drain();
  endtask

  task automatic run_phase(input int keys, input int any_key, input int idle, input int stall,
                           input int budget);
    program_cfg(keys, any_key);
    send_idle_pct = idle;
    stall_pct    <= stall;
    items_sent    = 0;
    while (items_sent < budget)
      run_frame();
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_KEYS_IN_USE;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset settings (256 keys, any-key code 255).
    // Last-key slots straight out of reset.
    send_item(make_item(MODE_QLAST, 8'd0, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_QLAST, 8'd0, EV_PRESSED, ST_DOWN));
    send_item(make_item(MODE_QLAST, 8'd0, EV_PRESSED, ST_PRESSED));
    send_item(make_item(MODE_QLAST, 8'd0, EV_PRESSED, ST_RELEASED));
    // any-key walk on an all-up table, then a plain miss
    send_item(make_item(MODE_QSTATE, 8'd255, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_QSTATE, 8'd0, EV_PRESSED, ST_PRESSED));
    // every event kind, the odd type three acting as repeat, key extremes
    send_item(make_item(MODE_POST, 8'd0, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_POST, 8'd255, EV_RELEASED, ST_RELEASED));
    send_item(make_item(MODE_POST, 8'd7, EV_REPEAT, ST_DOWN));
    send_item(make_item(MODE_POST, 8'd9, 2'd3, ST_PRESSED));
    send_item(make_item(MODE_POST, 8'd128, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_FLUSH, 8'd255, 2'd3, ST_RELEASED));
    // down answers for pressed; any-key walk finds the released key
    send_item(make_item(MODE_QSTATE, 8'd0, EV_PRESSED, ST_DOWN));
    send_item(make_item(MODE_QSTATE, 8'd0, EV_PRESSED, ST_PRESSED));
    send_item(make_item(MODE_QSTATE, 8'd255, EV_PRESSED, ST_RELEASED));
    send_item(make_item(MODE_QSTATE, 8'd128, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_QLAST, 8'd255, 2'd3, ST_UP));
    send_item(make_item(MODE_QLAST, 8'd255, 2'd3, ST_DOWN));
    send_item(make_item(MODE_QLAST, 8'd255, 2'd3, ST_PRESSED));
    send_item(make_item(MODE_QLAST, 8'd255, 2'd3, ST_RELEASED));
    // empty flush only ages: pressed turns to down
    send_item(make_item(MODE_FLUSH, 8'd0, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_QSTATE, 8'd0, EV_PRESSED, ST_PRESSED));
    // left queued: the next phase shrinks the key range, so key 200 is judged
    // out of range only when it is finally flushed
    send_item(make_item(MODE_POST, 8'd200, EV_PRESSED, ST_UP));
    send_item(make_item(MODE_POST, 8'd0, EV_RELEASED, ST_UP));
    drain();

    // Random phases: settings sweep the extremes, idling patterns rotate.
    run_phase(1, 0, 0, 0, 70);          // single key, any-key code is key 0
    run_phase(256, 255, 68, 0, 80);     // full range, idle sender
    run_phase(16, 200, 0, 68, 70);      // any-key code out of range, stalled sink
    run_phase(511, 137, 25, 25, 80);    // range above the table size clamps
    run_phase(0, 0, 0, 0, 40);          // no valid key at all
    run_phase(200, 199, 25, 25, 70);    // any-key code at the top of the range

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
